FILE: rtl/core/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg
// shared constants, types and helper functions of the position smoother
// ----------------------------------------------------------------------------
`default_nettype none

package aps_pkg;

  // number of lanes, one per axis
  localparam int AXES = 3;

  localparam int POS_W   = 32;
  localparam int TIME_W  = 24;
  localparam int RATIO_W = 21;
  localparam int NUM_W   = 46;
  localparam int DEN_W   = 27;
  localparam int MOD_W   = 25;

  localparam logic [TIME_W-1:0]  ONE_T     = 24'd1048576;
  localparam logic [TIME_W-1:0]  TINY_T    = 24'd1049;
  localparam logic [TIME_W-1:0]  TIME_MAX  = 24'hFFFFFF;
  localparam logic [RATIO_W-1:0] CAP_END   = 21'd1048576;
  localparam logic [RATIO_W-1:0] CAP_FREE  = 21'd1572864;
  localparam logic [RATIO_W-1:0] RATIO_DEF = 21'd838860;
  localparam logic [MOD_W-1:0]   DEG360    = 25'd23592960;
  localparam logic [MOD_W-1:0]   DEG180    = 25'd11796480;

  // ceil(2^28 / 10), exact floor division for numerators below 2^25
  localparam logic [24:0]        RECIP10   = 25'd26843546;

  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_TARGET  = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  typedef enum logic [3:0] {
    LC_NONE,
    LC_INIT,
    LC_TARGET,
    LC_DIFF,
    LC_FOLD,
    LC_MUL,
    LC_SUM,
    LC_PREP,
    LC_APPLY
  } lane_cmd_e;

  typedef struct packed {
    lane_cmd_e            cmd;
    logic                 wrap;
    logic [RATIO_W-1:0]   ratio;
  } lane_ctl_t;

  // v mod 360 degrees in Q16.16; 360 deg = 45 * 2^19, so only the upper
  // part needs a mod 45, done by reciprocal multiply
  function automatic logic [MOD_W-1:0] mod360(input logic signed [33:0] v);
    logic signed [14:0] hi;
    logic [15:0]        u;
    logic [30:0]        prod;
    logic [10:0]        q;
    logic [16:0]        qx45;
    logic [16:0]        rm;
    logic [5:0]         r6;
    hi   = v[33:19];
    u    = 16'($signed({hi[14], hi}) + 16'sd16425);
    prod = 31'(u) * 31'd23302;
    q    = prod[30:20];
    qx45 = 17'(q) * 17'd45;
    rm   = {1'b0, u} - qx45;
    if (rm >= 17'd45) begin
      rm = rm - 17'd45;
    end
    r6 = rm[5:0];
    return {r6, v[18:0]};
  endfunction

  function automatic logic [POS_W-1:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF) begin
      return 32'h7FFFFFFF;
    end else if (v < -36'sh080000000) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aps_in_if.sv
// ----------------------------------------------------------------------------
// aps_in_if
// input word channel of the position smoother
// ----------------------------------------------------------------------------
`default_nettype none

interface aps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] target_x;
  logic [31:0] target_y;
  logic [31:0] target_z;
  logic        target_is_end;
  logic [23:0] travel_interval;
  logic [23:0] time_step;

  modport source (
    output valid, operation, target_x, target_y, target_z, target_is_end,
           travel_interval, time_step,
    input  ready
  );
  modport sink (
    input  valid, operation, target_x, target_y, target_z, target_is_end,
           travel_interval, time_step,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/aps_out_if.sv
// ----------------------------------------------------------------------------
// aps_out_if
// result word channel of the position smoother
// ----------------------------------------------------------------------------
`default_nettype none

interface aps_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] current_x;
  logic [31:0] current_y;
  logic [31:0] current_z;

  modport source (output valid, current_x, current_y, current_z, input ready);
  modport sink (input valid, current_x, current_y, current_z, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/aps_div.sv
// ----------------------------------------------------------------------------
// aps_div
// restoring unsigned divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module aps_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [aps_pkg::NUM_W-1:0] num_i,
  input  wire logic [aps_pkg::DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic [aps_pkg::NUM_W-1:0]      quo_o
);

  localparam int STEPS = aps_pkg::NUM_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [aps_pkg::NUM_W-1:0] num_q, num_d;
  logic [aps_pkg::DEN_W:0]   rem_q, rem_d;
  logic [aps_pkg::DEN_W-1:0] den_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      run_q, done_q;

  logic [aps_pkg::DEN_W:0] r1, r1s, r2, r2s;
  logic                    b1, b2;

  always_comb begin
    r1  = {rem_q[aps_pkg::DEN_W-1:0], num_q[aps_pkg::NUM_W-1]};
    b1  = r1 >= {1'b0, den_q};
    r1s = b1 ? r1 - {1'b0, den_q} : r1;
    r2  = {r1s[aps_pkg::DEN_W-1:0], num_q[aps_pkg::NUM_W-2]};
    b2  = r2 >= {1'b0, den_q};
    r2s = b2 ? r2 - {1'b0, den_q} : r2;
    num_d = {num_q[aps_pkg::NUM_W-3:0], b1, b2};
    rem_d = r2s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(STEPS - 1);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

`default_nettype wire

FILE: rtl/core/aps_lane.sv
// ----------------------------------------------------------------------------
// aps_lane
// one axis: start, current and goal values and the step toward the goal
// ----------------------------------------------------------------------------
`default_nettype none

module aps_lane (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire aps_pkg::lane_ctl_t        ctl_i,
  input  wire logic [aps_pkg::POS_W-1:0] target_i,
  output logic [aps_pkg::POS_W-1:0]      cur_o
);

  logic [aps_pkg::POS_W-1:0] start_q, cur_q, goal_q;

  logic signed [33:0] diff_q;
  logic [aps_pkg::MOD_W-1:0] gap_q;
  logic [32:0] mag_q;
  logic        neg_q;
  logic [37:0] plo_q;
  logic [36:0] phi_q;
  logic signed [35:0] step_q;
  logic [aps_pkg::POS_W-1:0] lin_q;
  logic signed [35:0] cand_q;
  logic        take_goal_q;

  logic signed [33:0] g_m_s, g_m_c, folded, absd;
  logic [54:0]        psum;
  logic [34:0]        qmag;
  logic signed [35:0] s_ext, c_ext, gap_ext, rest_ext;

  always_comb begin
    g_m_s  = $signed({{2{goal_q[31]}}, goal_q}) - $signed({{2{start_q[31]}}, start_q});
    g_m_c  = $signed({{2{goal_q[31]}}, goal_q}) - $signed({{2{cur_q[31]}}, cur_q});
    folded = (ctl_i.wrap && diff_q > $signed({9'b0, aps_pkg::DEG180}))
             ? $signed({9'b0, aps_pkg::DEG360}) - diff_q : diff_q;
    absd   = folded[33] ? -folded : folded;
    psum   = {1'b0, phi_q, 17'b0} + {17'b0, plo_q} + 55'd524288;
    qmag   = psum[54:20];
    s_ext  = $signed({{4{start_q[31]}}, start_q});
    c_ext  = $signed({{4{cur_q[31]}}, cur_q});
    gap_ext  = $signed({11'b0, gap_q});
    rest_ext = $signed({11'b0, aps_pkg::DEG360}) - gap_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      cur_q   <= '0;
      goal_q  <= '0;
    end else begin
      case (ctl_i.cmd)
        aps_pkg::LC_INIT: begin
          start_q <= target_i;
          cur_q   <= target_i;
          goal_q  <= target_i;
        end
        aps_pkg::LC_TARGET: begin
          start_q <= cur_q;
          goal_q  <= target_i;
        end
        aps_pkg::LC_APPLY: begin
          if (ctl_i.wrap) begin
            cur_q <= take_goal_q ? goal_q
                     : {7'b0, aps_pkg::mod360(cand_q[33:0])};
          end else begin
            cur_q <= lin_q;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath of the advance step, no reset needed
  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      aps_pkg::LC_DIFF: begin
        diff_q <= ctl_i.wrap ? $signed({9'b0, aps_pkg::mod360(g_m_s)}) : g_m_s;
        gap_q  <= aps_pkg::mod360(g_m_c);
      end
      aps_pkg::LC_FOLD: begin
        neg_q <= folded[33];
        mag_q <= absd[32:0];
      end
      aps_pkg::LC_MUL: begin
        plo_q <= 38'(mag_q[16:0]) * 38'(ctl_i.ratio);
        phi_q <= 37'(mag_q[32:17]) * 37'(ctl_i.ratio);
      end
      aps_pkg::LC_SUM: begin
        step_q <= neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      end
      aps_pkg::LC_PREP: begin
        lin_q       <= aps_pkg::sat32(s_ext + step_q);
        take_goal_q <= !(gap_ext > step_q && rest_ext > step_q);
        cand_q      <= (gap_q > aps_pkg::DEG180) ? c_ext - step_q : c_ext + step_q;
      end
      default: ;
    endcase
  end

  assign cur_o = cur_q;

endmodule

`default_nettype wire

FILE: rtl/core/adaptive_position_smoother.sv
// from the accepting edge to a valid result word: advance runs the divider (start,
//   divide steps, done; none below TINY_T), six lane steps, output load; init, set
//   target and the unused code go to the output load (set target may average first)
// throughput: one word at a time, next accept in the cycle after the result loads
// reset: async rst_ni clears control state and positions; no clearing pass needed
// ----------------------------------------------------------------------------
// adaptive_position_smoother
// moves a per-axis current value toward its goal, linear or angle-wrapped
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_position_smoother (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  aps_in_if.sink    in_if,
  aps_out_if.source out_if,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RSTART = 4'd1;
  localparam logic [3:0] ST_RWAIT  = 4'd2;
  localparam logic [3:0] ST_EWAIT  = 4'd3;
  localparam logic [3:0] ST_DIFF   = 4'd4;
  localparam logic [3:0] ST_FOLD   = 4'd5;
  localparam logic [3:0] ST_MUL    = 4'd6;
  localparam logic [3:0] ST_SUM    = 4'd7;
  localparam logic [3:0] ST_PREP   = 4'd8;
  localparam logic [3:0] ST_APPLY  = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  logic [3:0] state_q, state_d;

  // shared timing state
  logic [aps_pkg::TIME_W-1:0]  est_q, est_d;
  logic [aps_pkg::TIME_W-1:0]  elapsed_q, elapsed_d;
  logic                        end_q, end_d;
  logic                        wrap_q;
  logic [aps_pkg::RATIO_W-1:0] ratio_q, ratio_d;

  // output register
  logic                      ovalid_q;
  logic [aps_pkg::POS_W-1:0] ox_q, oy_q, oz_q;

  logic accept;
  logic out_load;

  // divider hookup
  logic                      div_start;
  logic [aps_pkg::NUM_W-1:0] div_num;
  logic [aps_pkg::DEN_W-1:0] div_den;
  logic                      div_done;
  logic [aps_pkg::NUM_W-1:0] div_quo;

  aps_pkg::lane_ctl_t        lane_ctl;
  logic [aps_pkg::POS_W-1:0] in_tgt [3];
  logic [aps_pkg::POS_W-1:0] lane_cur [aps_pkg::AXES];
  logic [aps_pkg::POS_W-1:0] res [3];

  logic [aps_pkg::RATIO_W-1:0] cap;
  logic [aps_pkg::TIME_W:0]    el_sum;
  logic [27:0]                 blend;
  logic [24:0]                 blend_q;
  logic [49:0]                 avg_prod;

  assign accept    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);
  assign out_load  = (state_q == ST_OUT) && (!ovalid_q || out_if.ready);

  assign in_tgt[0] = in_if.target_x;
  assign in_tgt[1] = in_if.target_y;
  assign in_tgt[2] = in_if.target_z;

  assign cap    = end_q ? aps_pkg::CAP_END : aps_pkg::CAP_FREE;
  assign el_sum = {1'b0, elapsed_q} + {1'b0, in_if.time_step};
  // 9*interval + elapsed + 5, the numerator of the running average
  assign blend  = 28'({est_q, 3'b0}) + 28'(est_q) + 28'(elapsed_q) + 28'd5;
  // numerator / 10 by reciprocal multiply, only used while interval <= 1.0
  assign avg_prod = 50'(blend_q) * 50'(aps_pkg::RECIP10);

  always_comb begin
    state_d   = state_q;
    est_d     = est_q;
    elapsed_d = elapsed_q;
    end_d     = end_q;
    ratio_d   = ratio_q;
    div_start = 1'b0;
    // r = elapsed * 4 * 2^20 / (5 * interval)
    div_num   = {elapsed_q, 22'b0};
    div_den   = 27'({est_q, 2'b0}) + 27'(est_q);
    lane_ctl.cmd   = aps_pkg::LC_NONE;
    lane_ctl.wrap  = wrap_q;
    lane_ctl.ratio = ratio_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_if.operation)
            aps_pkg::OP_INIT: begin
              lane_ctl.cmd = aps_pkg::LC_INIT;
              est_d     = '0;
              end_d     = 1'b1;
              elapsed_d = '0;
              state_d   = ST_OUT;
            end
            aps_pkg::OP_TARGET: begin
              lane_ctl.cmd = aps_pkg::LC_TARGET;
              end_d     = in_if.target_is_end;
              elapsed_d = '0;
              state_d   = ST_OUT;
              if (in_if.travel_interval != '0) begin
                est_d = in_if.travel_interval;
              end else if (est_q < aps_pkg::TINY_T || est_q > aps_pkg::ONE_T) begin
                est_d = elapsed_q;
              end else begin
                // running average, numerator held in blend_q
                state_d = ST_EWAIT;
              end
            end
            aps_pkg::OP_ADVANCE: begin
              elapsed_d = el_sum[aps_pkg::TIME_W] ? aps_pkg::TIME_MAX
                          : el_sum[aps_pkg::TIME_W-1:0];
              state_d   = ST_RSTART;
            end
            default: state_d = ST_OUT;  // unused code only reports current
          endcase
        end
      end
      ST_RSTART: begin
        if (est_q >= aps_pkg::TINY_T) begin
          div_start = 1'b1;
          state_d   = ST_RWAIT;
        end else begin
          ratio_d = (aps_pkg::RATIO_DEF < cap) ? aps_pkg::RATIO_DEF : cap;
          state_d = ST_DIFF;
        end
      end
      ST_RWAIT: begin
        if (div_done) begin
          ratio_d = (div_quo < aps_pkg::NUM_W'(cap)) ? div_quo[aps_pkg::RATIO_W-1:0] : cap;
          state_d = ST_DIFF;
        end
      end
      ST_EWAIT: begin
        est_d   = {2'b0, avg_prod[49:28]};
        state_d = ST_OUT;
      end
      // lane steps, all axes in lockstep
      ST_DIFF: begin
        lane_ctl.cmd = aps_pkg::LC_DIFF;
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        lane_ctl.cmd = aps_pkg::LC_FOLD;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        lane_ctl.cmd = aps_pkg::LC_MUL;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        lane_ctl.cmd = aps_pkg::LC_SUM;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        lane_ctl.cmd = aps_pkg::LC_PREP;
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        lane_ctl.cmd = aps_pkg::LC_APPLY;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      est_q     <= '0;
      elapsed_q <= '0;
      end_q     <= 1'b1;
      wrap_q    <= 1'b0;
      ratio_q   <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      est_q     <= est_d;
      elapsed_q <= elapsed_d;
      end_q     <= end_d;
      ratio_q   <= ratio_d;
      if (cfg_we_i) begin
        wrap_q <= cfg_wdata_i;
      end
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_if.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // running-average numerator, captured before elapsed clears
  always_ff @(posedge clk_i) begin
    if (accept) begin
      blend_q <= blend[24:0];
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ox_q <= res[0];
      oy_q <= res[1];
      oz_q <= res[2];
    end
  end

  aps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // one lane per axis; axes past the third always aim at zero
  for (genvar i = 0; i < aps_pkg::AXES; i++) begin : g_lane
    logic [aps_pkg::POS_W-1:0] tgt;
    if (i < 3) begin : g_in
      assign tgt = in_tgt[i];
    end else begin : g_zero
      assign tgt = '0;
    end
    aps_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (lane_ctl),
      .target_i (tgt),
      .cur_o    (lane_cur[i])
    );
  end

  // merge: result fields without a lane read zero
  for (genvar i = 0; i < 3; i++) begin : g_res
    if (i < aps_pkg::AXES) begin : g_have
      assign res[i] = lane_cur[i];
    end else begin : g_none
      assign res[i] = '0;
    end
  end

  assign out_if.valid     = ovalid_q;
  assign out_if.current_x = ox_q;
  assign out_if.current_y = oy_q;
  assign out_if.current_z = oz_q;

endmodule

`default_nettype wire

FILE: rtl/core/aps_checker.sv
// ----------------------------------------------------------------------------
// aps_checker
// port-level checks of the position smoother
// ----------------------------------------------------------------------------
`default_nettype none

module aps_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [95:0] out_data_i
);

  // a result word waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("stalled result word changed");

  // one word in flight: input closes right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still open after accept");

  // a new result only appears while the input side is closed
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without work in progress");

endmodule

bind adaptive_position_smoother aps_checker u_aps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  ({out_if.current_x, out_if.current_y, out_if.current_z})
);

`default_nettype wire

FILE: tb/adaptive_position_smoother_test.sv
// ----------------------------------------------------------------------------
// adaptive_position_smoother_test
// self-checking bench: a clocked driver pushes words from a queue, a clocked
// monitor compares each result word with the smoother's predicted position
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module adaptive_position_smoother_test;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    logic        is_end;
    logic [23:0] interval;
    logic [23:0] dt;
  } word_t;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
  } pos_t;

  localparam int WATCH_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  aps_in_if  in_if ();
  aps_out_if out_if ();

  adaptive_position_smoother u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // smoother model state
  logic signed [31:0] start_pos [3];
  logic signed [31:0] cur_pos [3];
  logic signed [31:0] goal_pos [3];
  logic [23:0] est_interval;
  logic [23:0] elapsed;
  logic        goal_end;
  logic        wrap_mode;

  word_t pending_words [$];
  pos_t  expected_pos [$];
  int    mismatches = 0;
  int    checked = 0;
  int    idle_cycles = 0;
  bit    no_idle = 1'b0;
  bit    hold_off = 1'b0;
  int    src_gap = 0;
  int    snk_gap = 0;

  function automatic longint wrap360(longint v);
    longint m;
    m = v % (longint'(360) * 65536);
    if (m < 0) m += longint'(360) * 65536;
    return m;
  endfunction

  // magnitude rounding, ties away from zero
  function automatic longint scale_by(longint v, longint r);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * r + (longint'(1) << 19)) >>> 20;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  task automatic predict_position(input word_t w);
    longint d, stp, gap, c, r, capv, sum;
    logic signed [31:0] t [3];
    pos_t p;
    t[0] = w.tx; t[1] = w.ty; t[2] = w.tz;
    if (w.op == aps_pkg::OP_INIT || w.op == aps_pkg::OP_TARGET) begin
      for (int i = 0; i < 3; i++) begin
        if (w.op == aps_pkg::OP_INIT) begin
          start_pos[i] = t[i];
          cur_pos[i] = t[i];
        end else begin
          start_pos[i] = cur_pos[i];
        end
        goal_pos[i] = t[i];
      end
      if (w.op == aps_pkg::OP_INIT) begin
        est_interval = '0;
        goal_end = 1'b1;
      end else begin
        goal_end = w.is_end;
        if (w.interval != 0) est_interval = w.interval;
        else if (est_interval < aps_pkg::TINY_T || est_interval > aps_pkg::ONE_T)
          est_interval = elapsed;
        else est_interval = 24'((9 * longint'(est_interval) + elapsed + 5) / 10);
      end
      elapsed = '0;
    end else if (w.op == aps_pkg::OP_ADVANCE) begin
      sum = longint'(elapsed) + w.dt;
      elapsed = (sum > aps_pkg::TIME_MAX) ? aps_pkg::TIME_MAX : 24'(sum);
      capv = goal_end ? longint'(aps_pkg::CAP_END) : longint'(aps_pkg::CAP_FREE);
      if (est_interval >= aps_pkg::TINY_T)
        r = (longint'(elapsed) << 22) / (5 * longint'(est_interval));
      else r = aps_pkg::RATIO_DEF;
      if (r > capv) r = capv;
      for (int i = 0; i < 3; i++) begin
        if (wrap_mode) begin
          d = wrap360(longint'(goal_pos[i]) - start_pos[i]);
          if (d > aps_pkg::DEG180) d = aps_pkg::DEG360 - d;
          stp = scale_by(d, r);
          c = cur_pos[i];
          gap = wrap360(longint'(goal_pos[i]) - c);
          if (gap > stp && aps_pkg::DEG360 - gap > stp) begin
            c = (gap > aps_pkg::DEG180) ? c - stp : c + stp;
            cur_pos[i] = 32'(wrap360(c));
          end else begin
            cur_pos[i] = goal_pos[i];
          end
        end else begin
          cur_pos[i] = clamp32(longint'(start_pos[i]) + scale_by(
              longint'(goal_pos[i]) - start_pos[i], r));
        end
      end
    end
    p.cx = cur_pos[0]; p.cy = cur_pos[1]; p.cz = cur_pos[2];
    expected_pos.push_back(p);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h", what, got, want);
  endtask

  // driver: prediction happens at acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_position(word_t'({in_if.operation, in_if.target_x, in_if.target_y,
            in_if.target_z, in_if.target_is_end, in_if.travel_interval, in_if.time_step}));
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          word_t w;
          w = pending_words.pop_front();
          in_if.valid <= 1'b1;
          {in_if.operation, in_if.target_x, in_if.target_y, in_if.target_z,
           in_if.target_is_end, in_if.travel_interval, in_if.time_step} <= w;
          if (!no_idle && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 18);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare and drive ready with random stall bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        checked++;
        if (expected_pos.size() == 0) begin
          report_mismatch("unexpected word", out_if.current_x, 32'h0);
        end else begin
          pos_t e;
          e = expected_pos.pop_front();
          if (out_if.current_x !== e.cx) report_mismatch("current_x", out_if.current_x, e.cx);
          if (out_if.current_y !== e.cy) report_mismatch("current_y", out_if.current_y, e.cy);
          if (out_if.current_z !== e.cz) report_mismatch("current_z", out_if.current_z, e.cz);
        end
      end
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap <= snk_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 9) == 0) snk_gap <= $urandom_range(1, 18);
      end
      // watchdog on cycles with no handshake
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || hold_off)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCH_LIMIT) begin
        $display("adaptive_position_smoother verification failed");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_pos(input bit wrapped);
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return wrapped ? 32'($urandom_range(0, 23592959)) : $urandom;
      3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return wrapped ? 32'($urandom_range(0, 23592959)) : $urandom;
    endcase
  endfunction

  function automatic word_t rand_word(input bit wrapped);
    word_t w;
    int sel;
    sel = $urandom_range(0, 19);
    w.op = (sel < 2) ? aps_pkg::OP_INIT : (sel < 7) ? aps_pkg::OP_TARGET :
           (sel < 19) ? aps_pkg::OP_ADVANCE : aps_pkg::OP_UNUSED;
    w.tx = rand_pos(wrapped);
    w.ty = rand_pos(wrapped);
    w.tz = rand_pos(wrapped);
    w.is_end = 1'($urandom_range(0, 1));
    // interval 0 often so the estimator runs
    w.interval = ($urandom_range(0, 2) == 0) ? 24'd0 :
                 ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 300000));
    w.dt = ($urandom_range(0, 15) == 0) ? 24'($urandom) : 24'($urandom_range(0, 60000));
    return w;
  endfunction

  task automatic drain_all();
    while (pending_words.size() > 0 || expected_pos.size() > 0 || in_if.valid)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_wrap_mode(input logic v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wrap_mode = v;
  endtask

  function automatic word_t mk(input logic [1:0] op, input logic [31:0] x, y, z,
                               input logic e, input logic [23:0] iv, dt);
    return word_t'({op, x, y, z, e, iv, dt});
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = aps_pkg::OP_INIT;
    in_if.target_x = '0; in_if.target_y = '0; in_if.target_z = '0;
    in_if.target_is_end = 1'b0;
    in_if.travel_interval = '0;
    in_if.time_step = '0;
    out_if.ready = 1'b0;
    for (int i = 0; i < 3; i++) begin
      start_pos[i] = '0; cur_pos[i] = '0; goal_pos[i] = '0;
    end
    est_interval = '0; elapsed = '0; goal_end = 1'b1; wrap_mode = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every operation, estimator and saturation cases
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'hFFFFFF));
    pending_words.push_back(mk(aps_pkg::OP_UNUSED, 1, 2, 3, 1, 5, 5));
    pending_words.push_back(mk(aps_pkg::OP_INIT, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0));
    pending_words.push_back(mk(aps_pkg::OP_TARGET, 32'h7FFFFFFF, 32'h80000000, 32'h12345, 0,
                               24'd1048576, 0));
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'd2000000));
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'hFFFFFF));
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'hFFFFFF));
    pending_words.push_back(mk(aps_pkg::OP_TARGET, 32'h10000, 0, 32'hFFFF0000, 1, 24'd500, 0));
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'd100));
    pending_words.push_back(mk(aps_pkg::OP_TARGET, 0, 0, 0, 1, 0, 0));
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'd300000));
    pending_words.push_back(mk(aps_pkg::OP_TARGET, 32'h50000, 1, 2, 1, 0, 0));
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'd1048));
    pending_words.push_back(mk(aps_pkg::OP_TARGET, 32'h90000, 3, 4, 0, 0, 0));
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'd1049));
    drain_all();

    // angle mode directed: across 0/360 and beyond range inputs
    write_wrap_mode(1'b1);
    pending_words.push_back(mk(aps_pkg::OP_INIT, 32'd350 << 16, 32'd10 << 16, 0, 0, 0, 0));
    pending_words.push_back(mk(aps_pkg::OP_TARGET, 32'd10 << 16, 32'd350 << 16,
                               32'd180 << 16, 0, 24'd1048576, 0));
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'd400000));
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'd900000));
    pending_words.push_back(mk(aps_pkg::OP_TARGET, 32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000,
                               1, 24'd2000, 0));
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'd1000));
    pending_words.push_back(mk(aps_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 24'hFFFFFF));
    drain_all();

    // random phases, alternating mode; a long output stall in the second one
    for (int ph = 0; ph < 6; ph++) begin
      write_wrap_mode(ph[0]);
      for (int k = 0; k < 150; k++) pending_words.push_back(rand_word(ph[0]));
      if (ph == 1) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (600) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      if (ph == 5) no_idle = 1'b1;
      drain_all();
    end

    $display("covered %0d result words over linear and angle modes, both wrap settings,",
             checked);
    $display("estimated and given intervals, saturation and a long output stall");
    if (mismatches == 0) begin
      $display("adaptive_position_smoother verification clean");
    end else begin
      $display("adaptive_position_smoother verification failed");
    end
    $finish;
  end

endmodule
